// File: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// Multi-timer scheduler package
// Shared constants, command and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int DEF_TIME_BITS   = 48;

  localparam int ID_W       = 32;
  localparam int DUR_W      = 32;
  localparam int PORT_TIME_W = 48;
  localparam int WIN_W      = 8;
  localparam int MINP_W     = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 88;

  localparam logic [WIN_W-1:0]  WIN_RESET  = 8'd10;
  localparam logic [MINP_W-1:0] MINP_RESET = 16'd16;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_EARLY_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD   = 1'd1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic act;
    logic rd_fire;
    logic fire;
    logic emit;
    logic emit_last;
  } mts_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_create;
    logic is_delete;
    logic is_tick;
    logic pend_valid;
    logic cand_ok;
    logic out_free;
  } mts_stat_t;

endpackage

// File: sv/multi_timer_scheduler_top.sv
// ----------------------------------------------------------------------------
// Multi-timer scheduler
// Table of software timers with create, delete and tick commands.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer rule          Contents
//  in_      slave      in_tvalid & in_tready  tuser command; tdata timer fields
//  out_     master     out_tvalid & out_tready tuser status; tdata id, due, empty
//  cfg_     write      cfg_we                 early_fire_window, min_period
//
// Every command runs a scan of all slots, one slot per cycle from the table
// memories. Create and delete take two scans; a tick that fires k timers
// takes k + 1 scans, and a tick that fires nothing takes one scan.
// A new command is taken only when the previous one has handed all results to
// the output register; a stalled output holds the scheduler in place.
// Reset clears the slot valid bits and the control state.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_top #(
  parameter int TIMER_SLOTS = mts_pkg::DEF_TIMER_SLOTS,
  parameter int TIME_BITS   = mts_pkg::DEF_TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // timer_id[31:0], duration_ms[63:32], scheduled_time_ms[111:64],
  // repeat_flag[112], now_ms[160:113]
  input  logic [mts_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [mts_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fired_id[31:0], next_due_ms[79:32], table_empty[80]
  output logic [mts_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [mts_pkg::STATUS_W-1:0]   out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mts_pkg::mts_cmd_t  cmd;
  mts_pkg::mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mts_dp #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sv/mts_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-timer scheduler controller
// Sequences slot scans, table updates, timer firing and result transfers.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mts_pkg::mts_stat_t stat,
  output mts_pkg::mts_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_EVAL = 7'b0000100,
    S_ACT  = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_READ = 7'b0100000,
    S_FIRE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   post_r, post_nxt;
  logic   cand_ok_eff;
  logic   emit_needed;

  assign cand_ok_eff = stat.is_tick && stat.cand_ok;
  assign emit_needed = stat.pend_valid || !cand_ok_eff;
  assign in_tready   = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    post_nxt  = post_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          post_nxt       = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if ((stat.is_create || stat.is_delete) && !post_r) begin
          state_nxt = S_ACT;
        end else if (emit_needed) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_ACT: begin
        cmd.act        = 1'b1;
        cmd.scan_start = 1'b1;
        post_nxt       = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = !cand_ok_eff;
          state_nxt     = cand_ok_eff ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_fire = 1'b1;
        state_nxt   = S_FIRE;
      end
      S_FIRE: begin
        cmd.fire       = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      post_r  <= post_nxt;
    end
  end

endmodule

// File: sv/mts_dp.sv
// ----------------------------------------------------------------------------
// Multi-timer scheduler datapath
// Timer table memories, slot scan, table updates and the result register.
// ----------------------------------------------------------------------------
module mts_dp #(
  parameter int TIMER_SLOTS = mts_pkg::DEF_TIMER_SLOTS,
  parameter int TIME_BITS   = mts_pkg::DEF_TIME_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mts_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [mts_pkg::CMD_W-1:0]         in_tuser,
  input  logic                              cfg_we,
  input  logic [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  mts_pkg::mts_cmd_t                 cmd,
  output mts_pkg::mts_stat_t                stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mts_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [mts_pkg::STATUS_W-1:0]      out_tuser,
  output logic                              out_tlast
);

  localparam int TW = TIME_BITS;
  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int PW = mts_pkg::PORT_TIME_W;
  localparam logic [TW-1:0] TMAX = '1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                            input logic [mts_pkg::DUR_W-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + (TW+1)'(b);
    return s[TW] ? TMAX : s[TW-1:0];
  endfunction

  // Configuration registers
  logic [mts_pkg::WIN_W-1:0]  win_r;
  logic [mts_pkg::MINP_W-1:0] minp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= mts_pkg::WIN_RESET;
      minp_r <= mts_pkg::MINP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mts_pkg::CFG_EARLY_WINDOW: win_r  <= cfg_wdata[mts_pkg::WIN_W-1:0];
        mts_pkg::CFG_MIN_PERIOD:   minp_r <= cfg_wdata;
      endcase
    end
  end

  // Latched input item
  logic [mts_pkg::CMD_W-1:0] cmd_r;
  logic [mts_pkg::ID_W-1:0]  id_r;
  logic [mts_pkg::DUR_W-1:0] dur_r;
  logic [TW-1:0]             due_r;
  logic [TW-1:0]             now_r;
  logic                      rep_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_tuser;
      id_r  <= in_tdata[31:0];
      dur_r <= in_tdata[63:32];
      due_r <= sat_add(TW'(in_tdata[111:64]), in_tdata[63:32]);
      rep_r <= in_tdata[112];
      now_r <= TW'(in_tdata[160:113]);
    end
  end

  // Table state
  logic [TIMER_SLOTS-1:0] valid_r;
  logic [TIMER_SLOTS-1:0] fired_r;

  logic [mts_pkg::ID_W-1:0]  id_mem  [TIMER_SLOTS];
  logic [TW-1:0]             due_mem [TIMER_SLOTS];
  logic [mts_pkg::DUR_W-1:0] per_mem [TIMER_SLOTS];
  logic                      rep_mem [TIMER_SLOTS];

  logic [mts_pkg::ID_W-1:0]  rd_id_r;
  logic [TW-1:0]             rd_due_r;
  logic [mts_pkg::DUR_W-1:0] rd_per_r;
  logic                      rd_rep_r;

  // Scan state
  logic          scan_act_r;
  logic [IW-1:0] scan_cnt_r;
  logic          rd_v_r;
  logic [IW-1:0] rd_idx_r;
  logic [TW-1:0] min_all_r;
  logic          cand_found_r;
  logic [IW-1:0] cand_idx_r;
  logic [TW-1:0] cand_due_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  logic          match_found_r;
  logic [IW-1:0] match_idx_r;

  // Pending result
  logic                         pend_valid_r;
  logic [mts_pkg::STATUS_W-1:0] pend_status_r;
  logic [mts_pkg::ID_W-1:0]     pend_id_r;

  // Result register
  logic                         out_valid_r;
  logic [mts_pkg::STATUS_W-1:0] out_status_r;
  logic [mts_pkg::ID_W-1:0]     out_id_r;
  logic [PW-1:0]                out_due_r;
  logic                         out_empty_r;
  logic                         out_last_r;

  logic                      is_create;
  logic                      is_delete;
  logic                      immediate;
  logic                      cr_we;
  logic                      due_we;
  logic [IW-1:0]             wr_idx;
  logic [TW-1:0]             due_wdata;
  logic [mts_pkg::DUR_W-1:0] per_val;
  logic [IW-1:0]             rd_addr;
  logic                      sv;
  logic                      sf;
  logic                      cand_ok;
  logic                      out_free;

  assign is_create = (cmd_r == mts_pkg::CMD_CREATE);
  assign is_delete = (cmd_r == mts_pkg::CMD_DELETE);
  assign immediate = !rep_r && (due_r <= now_r);
  assign cr_we     = cmd.act && is_create && !immediate && free_found_r;
  assign due_we    = cr_we || (cmd.fire && rd_rep_r);
  assign wr_idx    = cmd.fire ? cand_idx_r : free_idx_r;
  assign due_wdata = cmd.fire ? sat_add(now_r, rd_per_r) : due_r;
  assign per_val   = (dur_r < mts_pkg::DUR_W'(minp_r)) ? mts_pkg::DUR_W'(minp_r) : dur_r;
  assign rd_addr   = cmd.rd_fire ? cand_idx_r : scan_cnt_r;
  assign sv        = valid_r[rd_idx_r];
  assign sf        = fired_r[rd_idx_r];
  assign cand_ok   = cand_found_r &&
                     ((cand_due_r < TW'(win_r)) || (now_r > cand_due_r - TW'(win_r)));
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[wr_idx] <= due_wdata;
    end
    if (cr_we) begin
      id_mem[free_idx_r]  <= id_r;
      per_mem[free_idx_r] <= per_val;
      rep_mem[free_idx_r] <= rep_r;
    end
    rd_id_r  <= id_mem[rd_addr];
    rd_due_r <= due_mem[rd_addr];
    rd_per_r <= per_mem[rd_addr];
    rd_rep_r <= rep_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fired_r <= '0;
    end else begin
      if (cr_we) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.act && is_delete && match_found_r) begin
        valid_r[match_idx_r] <= 1'b0;
      end
      if (cmd.fire && !rd_rep_r) begin
        valid_r[cand_idx_r] <= 1'b0;
      end
      if (cmd.load) begin
        fired_r <= '0;
      end else if (cmd.fire) begin
        fired_r[cand_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      rd_v_r     <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      rd_v_r <= scan_act_r;
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
        scan_cnt_r <= '0;
      end else if (scan_act_r) begin
        scan_cnt_r <= scan_cnt_r + IW'(1);
        if (scan_cnt_r == LAST_IDX) begin
          scan_act_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_cnt_r;
    if (cmd.scan_start) begin
      min_all_r     <= TMAX;
      cand_found_r  <= 1'b0;
      free_found_r  <= 1'b0;
      match_found_r <= 1'b0;
    end else if (rd_v_r) begin
      if (sv && (rd_due_r < min_all_r)) begin
        min_all_r <= rd_due_r;
      end
      if (sv && !sf && (!cand_found_r || (rd_due_r < cand_due_r))) begin
        cand_found_r <= 1'b1;
        cand_idx_r   <= rd_idx_r;
        cand_due_r   <= rd_due_r;
      end
      if (!sv && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (sv && (rd_id_r == id_r) && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load || cmd.emit) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.act || cmd.fire) begin
      pend_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      pend_status_r <= mts_pkg::ST_FIRED;
      pend_id_r     <= rd_id_r;
    end else if (cmd.act) begin
      pend_id_r <= '0;
      if (is_create) begin
        if (immediate) begin
          pend_status_r <= mts_pkg::ST_FIRED;
          pend_id_r     <= id_r;
        end else if (!free_found_r) begin
          pend_status_r <= mts_pkg::ST_FULL;
        end else begin
          pend_status_r <= mts_pkg::ST_CREATED;
        end
      end else begin
        pend_status_r <= match_found_r ? mts_pkg::ST_DELETED : mts_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= pend_valid_r ? pend_status_r : mts_pkg::ST_NONE;
      out_id_r     <= pend_valid_r ? pend_id_r : '0;
      out_due_r    <= PW'(min_all_r);
      out_empty_r  <= ~|valid_r;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_empty_r, out_due_r, out_id_r};

  assign stat.scan_done  = !scan_act_r && !rd_v_r;
  assign stat.is_create  = is_create;
  assign stat.is_delete  = is_delete;
  assign stat.is_tick    = (cmd_r == mts_pkg::CMD_TICK);
  assign stat.pend_valid = pend_valid_r;
  assign stat.cand_ok    = cand_ok;
  assign stat.out_free   = out_free;

`ifndef SYNTH
  a_fire_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |-> valid_r[cand_idx_r] && !fired_r[cand_idx_r])
    else $error("Fire targets a slot that is empty or already fired.");

  a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
    cr_we |-> !valid_r[free_idx_r])
    else $error("Create overwrites an occupied slot.");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("Result loaded while the previous one is still held.");

  a_empty_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_due_r == PW'(TMAX))
    else $error("Empty table reports a finite next due time.");

  a_fired_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> fired_r == '0)
    else $error("Fired marks survive into a new command.");
`endif

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Multi-timer scheduler testbench
// Drives create, delete and tick commands into the timer table: a short
// table of directed commands, then several phases of random traffic under
// different window and minimum period settings. Every result transfer is
// checked against the directed row's result where one is given, else against
// a cycle-free model of the timer table kept here. Both sides of the stream
// idle at random; once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import mts_pkg::*;

  localparam int TIMER_SLOTS = DEF_TIMER_SLOTS;
  localparam int SETTLE_CYCLES = 2 * TIMER_SLOTS + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 46;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [PORT_TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ID_W-1:0]        fired_id;
    logic [PORT_TIME_W-1:0] next_due;
    logic                   empty;
    logic                   last;
  } timer_result_t;

  localparam timer_result_t NO_RESULT = '0;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [ID_W-1:0]        id;
    logic [DUR_W-1:0]       dur;
    logic [PORT_TIME_W-1:0] sched;
    logic                   rep;
    logic [PORT_TIME_W-1:0] now;
    logic [4:0]             copies;
    logic                   typed;
    timer_result_t          want;
  } stim_row_t;

  localparam int PLAN_ROWS = 15;

  stim_row_t plan [PLAN_ROWS] = '{
    '{CMD_TICK, 32'd0, 32'd0, 48'd0, 1'b0, 48'd0, 5'd1, 1'b1,
      '{ST_NONE, 32'd0, TIME_MAX, 1'b1, 1'b1}},
    '{CMD_DELETE, 32'd5, 32'd0, 48'd0, 1'b0, 48'd0, 5'd1, 1'b1,
      '{ST_NOT_FOUND, 32'd0, TIME_MAX, 1'b1, 1'b1}},
    '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX, 1'b1, TIME_MAX, 5'd1, 1'b1,
      '{ST_NONE, 32'd0, TIME_MAX, 1'b1, 1'b1}},
    '{CMD_CREATE, 32'hFFFF_FFFF, 32'd0, 48'd0, 1'b0, 48'd0, 5'd1, 1'b1,
      '{ST_FIRED, 32'hFFFF_FFFF, TIME_MAX, 1'b1, 1'b1}},
    '{CMD_CREATE, 32'd1, 32'd50, 48'd100, 1'b0, 48'd100, 5'd1, 1'b1,
      '{ST_CREATED, 32'd0, 48'd150, 1'b0, 1'b1}},
    '{CMD_CREATE, 32'd2, 32'd0, 48'd100, 1'b1, 48'd200, 5'd1, 1'b1,
      '{ST_CREATED, 32'd0, 48'd100, 1'b0, 1'b1}},
    '{CMD_CREATE, 32'd2, 32'd5, 48'd120, 1'b1, 48'd200, 5'd1, 1'b1,
      '{ST_CREATED, 32'd0, 48'd100, 1'b0, 1'b1}},
    '{CMD_CREATE, 32'd3, 32'hFFFF_FFFF, TIME_MAX, 1'b0, 48'd0, 5'd1, 1'b1,
      '{ST_CREATED, 32'd0, 48'd100, 1'b0, 1'b1}},
    '{CMD_CREATE, 32'd4, 32'd3, 48'd0, 1'b0, 48'd0, 5'd1, 1'b1,
      '{ST_CREATED, 32'd0, 48'd3, 1'b0, 1'b1}},
    '{CMD_CREATE, 32'h100, 32'd1000, 48'd100, 1'b1, 48'd100, 5'd11, 1'b0, NO_RESULT},
    '{CMD_CREATE, 32'd9, 32'd10, 48'd0, 1'b0, 48'd0, 5'd1, 1'b1,
      '{ST_FULL, 32'd0, 48'd3, 1'b0, 1'b1}},
    '{CMD_TICK, 32'd0, 32'd0, 48'd0, 1'b0, 48'd0, 5'd1, 1'b0, NO_RESULT},
    '{CMD_TICK, 32'd0, 32'd0, 48'd0, 1'b0, TIME_MAX, 5'd1, 1'b0, NO_RESULT},
    '{CMD_DELETE, 32'd2, 32'd0, 48'd0, 1'b0, 48'd0, 5'd1, 1'b0, NO_RESULT},
    '{CMD_DELETE, 32'h100, 32'd0, 48'd0, 1'b0, 48'd0, 5'd1, 1'b0, NO_RESULT}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [CMD_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bit                     slot_used [TIMER_SLOTS];
  logic [ID_W-1:0]        slot_id [TIMER_SLOTS];
  logic [PORT_TIME_W-1:0] slot_due [TIMER_SLOTS];
  logic [DUR_W-1:0]       slot_period [TIMER_SLOTS];
  bit                     slot_rep [TIMER_SLOTS];
  logic [WIN_W-1:0]       fire_window;
  logic [MINP_W-1:0]      shortest_period;

  timer_result_t          step_results[$];
  timer_result_t          awaited_results[$];
  timer_result_t          seen;
  timer_result_t          oldest;
  logic [PORT_TIME_W-1:0] wall_ms;
  int                     mismatches;
  int                     quiet_cycles;
  int                     hold_left;
  bit                     hold_pending;
  bit                     no_idle;

  multi_timer_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [PORT_TIME_W-1:0] clamp_add(input logic [PORT_TIME_W-1:0] a,
                                                        input logic [PORT_TIME_W-1:0] b);
    logic [PORT_TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[PORT_TIME_W] ? TIME_MAX : sum[PORT_TIME_W-1:0];
  endfunction

  function automatic logic [PORT_TIME_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PORT_TIME_W-1:0];
  endfunction

  function automatic timer_result_t table_view(input logic [STATUS_W-1:0] status,
                                               input logic [ID_W-1:0] id);
    timer_result_t r;
    int i;
    r.status = status;
    r.fired_id = id;
    r.next_due = TIME_MAX;
    r.empty = 1'b1;
    r.last = 1'b0;
    for (i = 0; i < TIMER_SLOTS; i++) begin
      if (slot_used[i]) begin
        r.empty = 1'b0;
        if (slot_due[i] < r.next_due) r.next_due = slot_due[i];
      end
    end
    return r;
  endfunction

  task automatic timer_table_step(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                  input logic [DUR_W-1:0] dur,
                                  input logic [PORT_TIME_W-1:0] sched, input logic rep,
                                  input logic [PORT_TIME_W-1:0] now);
    logic [PORT_TIME_W-1:0] due;
    logic [PORT_TIME_W-1:0] win;
    int free_slot;
    int sel;
    int i;
    bit found;
    bit done;
    bit fired [TIMER_SLOTS];
    step_results.delete();
    win = {{(PORT_TIME_W-WIN_W){1'b0}}, fire_window};
    case (cmd)
      CMD_CREATE: begin
        due = clamp_add(sched, {16'd0, dur});
        if (!rep && due <= now) begin
          step_results = {step_results, table_view(ST_FIRED, id)};
        end else begin
          free_slot = -1;
          for (i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!slot_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            step_results = {step_results, table_view(ST_FULL, '0)};
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_id[free_slot] = id;
            slot_due[free_slot] = due;
            slot_period[free_slot] = (dur < {16'd0, shortest_period}) ?
                                     {16'd0, shortest_period} : dur;
            slot_rep[free_slot] = rep;
            step_results = {step_results, table_view(ST_CREATED, '0)};
          end
        end
      end
      CMD_DELETE: begin
        found = 1'b0;
        for (i = 0; i < TIMER_SLOTS; i++) begin
          if (!found && slot_used[i] && slot_id[i] == id) begin
            slot_used[i] = 1'b0;
            found = 1'b1;
          end
        end
        step_results = {step_results, table_view(found ? ST_DELETED : ST_NOT_FOUND, '0)};
      end
      CMD_TICK: begin
        foreach (fired[k]) fired[k] = 1'b0;
        done = 1'b0;
        while (!done) begin
          sel = -1;
          for (i = 0; i < TIMER_SLOTS; i++) begin
            if (slot_used[i] && !fired[i] && (sel < 0 || slot_due[i] < slot_due[sel]))
              sel = i;
          end
          if (sel < 0) begin
            done = 1'b1;
          end else if (!(slot_due[sel] < win || now > slot_due[sel] - win)) begin
            done = 1'b1;
          end else begin
            fired[sel] = 1'b1;
            if (slot_rep[sel]) slot_due[sel] = clamp_add(now, {16'd0, slot_period[sel]});
            else slot_used[sel] = 1'b0;
            step_results = {step_results, table_view(ST_FIRED, slot_id[sel])};
          end
        end
        if (step_results.size() == 0) step_results = {step_results, table_view(ST_NONE, '0)};
      end
      default: begin
        step_results = {step_results, table_view(ST_NONE, '0)};
      end
    endcase
    step_results[step_results.size() - 1].last = 1'b1;
  endtask

  task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                               input logic [DUR_W-1:0] dur,
                               input logic [PORT_TIME_W-1:0] sched, input logic rep,
                               input logic [PORT_TIME_W-1:0] now, input bit typed,
                               input timer_result_t want);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {{(IN_DATA_W-161){1'b0}}, now, rep, sched, dur, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    timer_table_step(cmd, id, dur, sched, rep, now);
    if (typed) awaited_results = {awaited_results, want};
    else awaited_results = {awaited_results, step_results};
    @(negedge clk);
  endtask

  task automatic offer_random();
    int pick;
    int count;
    int nth;
    int i;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0] id;
    logic [DUR_W-1:0] dur;
    logic [PORT_TIME_W-1:0] sched;
    logic [PORT_TIME_W-1:0] now;
    logic [PORT_TIME_W-1:0] back;
    logic rep;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 23);
    dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
    rep = ($urandom_range(0, 2) == 0);
    back = 48'($urandom_range(0, 40));
    sched = (wall_ms > back) ? wall_ms - back : '0;
    now = wall_ms;
    cmd = CMD_CREATE;
    if (pick < 40) begin
      cmd = CMD_CREATE;
    end else if (pick < 60) begin
      cmd = CMD_DELETE;
      count = 0;
      foreach (slot_used[k]) if (slot_used[k]) count++;
      if (count > 0 && $urandom_range(0, 1) == 1) begin
        nth = $urandom_range(0, count - 1);
        for (i = 0; i < TIMER_SLOTS; i++) begin
          if (slot_used[i]) begin
            if (nth == 0) id = slot_id[i];
            nth--;
          end
        end
      end
    end else if (pick < 92) begin
      cmd = CMD_TICK;
      wall_ms = clamp_add(wall_ms, 48'($urandom_range(0, 80)));
      now = wall_ms;
    end else begin
      cmd = 2'($urandom_range(0, 3));
      id = $urandom;
      dur = $urandom;
      sched = rand48();
      rep = 1'($urandom_range(0, 1));
      now = rand48();
    end
    offer_command(cmd, id, dur, sched, rep, now, 1'b0, NO_RESULT);
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_registers(input logic [CFG_DATA_W-1:0] win_word,
                                 input logic [CFG_DATA_W-1:0] period_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_EARLY_WINDOW;
    cfg_wdata <= win_word;
    @(negedge clk);
    cfg_index <= CFG_MIN_PERIOD;
    cfg_wdata <= period_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    fire_window = win_word[WIN_W-1:0];
    shortest_period = period_word;
    @(negedge clk);
  endtask

  task automatic clear_table();
    logic [ID_W-1:0] ids[$];
    foreach (slot_used[k]) if (slot_used[k]) ids = {ids, slot_id[k]};
    foreach (ids[k]) offer_command(CMD_DELETE, ids[k], '0, '0, 1'b0, '0, 1'b0, NO_RESULT);
  endtask

  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.status = out_tuser;
      seen.fired_id = out_tdata[31:0];
      seen.next_due = out_tdata[79:32];
      seen.empty = out_tdata[80];
      seen.last = out_tlast;
      if (awaited_results.size() == 0) begin
        $display("%0t: expected no result, actual status %0d id %h due %h empty %b last %b",
                 $time, seen.status, seen.fired_id, seen.next_due, seen.empty, seen.last);
        mismatches++;
      end else begin
        oldest = awaited_results.pop_front();
        if (seen.status != oldest.status || seen.fired_id != oldest.fired_id ||
            seen.next_due != oldest.next_due || seen.empty != oldest.empty ||
            seen.last != oldest.last) begin
          $display("%0t: expected status %0d id %h due %h empty %b last %b", $time,
                   oldest.status, oldest.fired_id, oldest.next_due, oldest.empty,
                   oldest.last);
          $display("%0t:   actual status %0d id %h due %h empty %b last %b", $time,
                   seen.status, seen.fired_id, seen.next_due, seen.empty, seen.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multi_timer_scheduler_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int c;
    logic [CFG_DATA_W-1:0] win_word;
    logic [CFG_DATA_W-1:0] period_word;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_CREATE;
    cfg_we = 1'b0;
    cfg_index = CFG_EARLY_WINDOW;
    cfg_wdata = '0;
    mismatches = 0;
    quiet_cycles = 0;
    hold_pending = 1'b0;
    no_idle = 1'b0;
    wall_ms = '0;
    foreach (slot_used[k]) slot_used[k] = 1'b0;
    fire_window = WIN_RESET;
    shortest_period = MINP_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      for (c = 0; c < int'(plan[r].copies); c++)
        offer_command(plan[r].cmd, plan[r].id + 32'(c), plan[r].dur, plan[r].sched,
                      plan[r].rep, plan[r].now, plan[r].typed, plan[r].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      case (phase)
        0: begin
          win_word = 16'd0;
          period_word = 16'd1;
          wall_ms = '0;
        end
        1: begin
          win_word = 16'd255;
          period_word = 16'hFFFF;
          wall_ms = TIME_MAX - 48'($urandom_range(0, 3000));
        end
        2: begin
          win_word = 16'($urandom_range(0, 255));
          period_word = 16'd0;
          wall_ms = rand48();
        end
        3: begin
          win_word = 16'($urandom);
          period_word = 16'($urandom_range(1, 65535));
          wall_ms = rand48();
        end
        4: begin
          win_word = 16'($urandom_range(0, 64));
          period_word = 16'($urandom_range(1, 200));
          wall_ms = rand48();
        end
        default: begin
          win_word = {8'd0, WIN_RESET};
          period_word = MINP_RESET;
          wall_ms = rand48();
        end
      endcase
      write_registers(win_word, period_word);
      no_idle = (phase == 4);
      clear_table();
      if (phase == 2) hold_pending = 1'b1;
      repeat (ITEMS_PER_PHASE) offer_random();
    end

    settle_idle();
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("multi_timer_scheduler_top: match");
    end else begin
      $display("multi_timer_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule
